// File: sv/pmt_section_stream_parser_unit_macros.svh
// assertion macros for the pmt section parser
`ifndef PMT_SECTION_STREAM_PARSER_UNIT_MACROS_SVH
`define PMT_SECTION_STREAM_PARSER_UNIT_MACROS_SVH

`ifndef SYNTH
`define PMT_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define PMT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PMT_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define PMT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// File: sv/pmt_pkg.sv
package pmt_pkg;

   localparam int POSITION_WIDTH = 16;

   typedef logic [POSITION_WIDTH-1:0] pos_type;

   localparam pos_type POS_MAX = {POSITION_WIDTH{1'b1}};

   // header byte offsets
   localparam pos_type POS_TID       = pos_type'(0);
   localparam pos_type POS_LEN_HI    = pos_type'(1);
   localparam pos_type POS_LEN_LO    = pos_type'(2);
   localparam pos_type POS_PROG_HI   = pos_type'(3);
   localparam pos_type POS_PROG_LO   = pos_type'(4);
   localparam pos_type POS_VERSION   = pos_type'(5);
   localparam pos_type POS_PINFO_HI  = pos_type'(10);
   localparam pos_type POS_PINFO_LO  = pos_type'(11);
   localparam pos_type HEADER_BYTES  = pos_type'(12);

   localparam int ENTRY_LEN = 5;

   typedef enum logic [1:0] {
      CSR_TID       = 2'd0,
      CSR_MAX_BYTES = 2'd1,
      CSR_MIN_BYTES = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_SHORT     = 2'd1,
      STATUS_TRUNCATED = 2'd2,
      STATUS_BAD_HDR   = 2'd3
   } status_type;

   typedef enum logic {
      KIND_ENTRY = 1'b0,
      KIND_CLOSE = 1'b1
   } kind_type;

   typedef struct packed {
      logic [7:0]  expected_tid;
      logic [12:0] max_section_bytes;
      logic [12:0] min_buffer_bytes;
   } cfg_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  es_type;
      logic [12:0] es_pid;
      logic [15:0] prog_no;
      logic [4:0]  version;
      logic [1:0]  status;
      logic        last;
   } result_type;

   // up to two results per accepted item, first in a, second in b
   typedef struct packed {
      logic [1:0] count;
      result_type a;
      result_type b;
   } push_type;

endpackage

// File: sv/pmt_interfaces.sv
interface pmt_req_if;
   import pmt_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   modport source (output valid, data_byte, last_byte, input ready);
   modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface pmt_rsp_if;
   import pmt_pkg::*;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  es_type;
   logic [12:0] es_pid;
   logic [15:0] prog_no;
   logic [4:0]  version;
   logic [1:0]  status;
   logic        last;
   modport source (output valid, kind, es_type, es_pid, prog_no,
                   version, status, last, input ready);
   modport sink (input valid, kind, es_type, es_pid, prog_no,
                 version, status, last, output ready);
endinterface

interface pmt_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [12:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: sv/pmt_section_stream_parser_unit.sv
// pmt section stream parser: one section byte per item, entries and a closing result out
// a result is written to the result queue when the item that causes it is taken
// throughput: one item per cycle while the result queue holds at most two results
// an item with both an entry and a closing result pushes both results in the same cycle
// reset: synchronous, active high; clears section state, queue and config to defaults
`include "pmt_section_stream_parser_unit_macros.svh"

module pmt_section_stream_parser_unit (
   input logic       clock,
   input logic       reset,
   pmt_req_if.sink   req_chan,
   pmt_rsp_if.source rsp_chan,
   pmt_csr_if.sink   csr_chan
);
   import pmt_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   push_type   push;
   result_type head;
   logic       has_room;
   logic       req_accept;
   logic       csr_write;

   // configuration registers, writes to unknown indexes fall through
   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid && csr_chan.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_chan.index)
            CSR_TID:       cfg_in.expected_tid      = csr_chan.data[7:0];
            CSR_MAX_BYTES: cfg_in.max_section_bytes = csr_chan.data;
            CSR_MIN_BYTES: cfg_in.min_buffer_bytes  = csr_chan.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_tid      <= 8'd2;
         cfg_ff.max_section_bytes <= 13'd1024;
         cfg_ff.min_buffer_bytes  <= 13'd16;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // an item is taken whenever the queue can absorb two results
   assign req_chan.ready = has_room;
   assign req_accept     = req_chan.valid && has_room;

   // byte parser: header capture, entry window, closing status
   pmt_parse_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .data_byte (req_chan.data_byte),
      .last_byte (req_chan.last_byte),
      .cfg       (cfg_ff),
      .push      (push)
   );

   // result queue parts the byte side from the result side
   pmt_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .has_room  (has_room),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (head)
   );

   assign rsp_chan.kind    = head.kind;
   assign rsp_chan.es_type = head.es_type;
   assign rsp_chan.es_pid  = head.es_pid;
   assign rsp_chan.prog_no = head.prog_no;
   assign rsp_chan.version = head.version;
   assign rsp_chan.status  = head.status;
   assign rsp_chan.last    = head.last;

   // checks
   `PMT_ASSERT_NEXT(a_close_offered, clock, reset, req_accept && req_chan.last_byte, rsp_chan.valid, "closing item not queued")
   `PMT_ASSERT_IMPLIES(a_last_is_close, clock, reset, rsp_chan.valid && rsp_chan.last, rsp_chan.kind == KIND_CLOSE, "last flag on an entry")
   `PMT_ASSERT_IMPLIES(a_entry_clean, clock, reset, rsp_chan.valid && rsp_chan.kind == KIND_ENTRY, rsp_chan.status == STATUS_OK && !rsp_chan.last, "entry with status or last")
   `PMT_ASSERT_IMPLIES(a_stall_means_backlog, clock, reset, !req_chan.ready, rsp_chan.valid, "input stalled with empty queue")

endmodule

// File: sv/pmt_result_fifo.sv
module pmt_result_fifo (
   input  logic             clock,
   input  logic             reset,
   input  pmt_pkg::push_type push,
   output logic             has_room,
   output logic             out_valid,
   input  logic             out_ready,
   output pmt_pkg::result_type out_data
);
   import pmt_pkg::*;

   localparam int DEPTH = 4;

   result_type  mem_ff [DEPTH];
   logic [1:0]  head_ff, head_in;
   logic [1:0]  tail_ff, tail_in;
   logic [2:0]  count_ff, count_in;
   logic        pop;

   assign out_valid = (count_ff != 3'd0);
   assign out_data  = mem_ff[head_ff];
   assign has_room  = (count_ff <= 3'd2);
   assign pop       = out_valid && out_ready;

   always_comb begin
      head_in  = head_ff + {1'b0, pop};
      tail_in  = tail_ff + push.count;
      count_in = count_ff + {1'b0, push.count} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[tail_ff] <= push.a;
      end
      if (push.count == 2'd2) begin
         mem_ff[tail_ff + 2'd1] <= push.b;
      end
   end

endmodule

// File: sv/pmt_parse_core.sv
module pmt_parse_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        data_byte,
   input  logic              last_byte,
   input  pmt_pkg::cfg_type  cfg,
   output pmt_pkg::push_type push
);
   import pmt_pkg::*;

   pos_type     pos_ff, pos_in;
   logic        bad_ff, bad_in;
   logic [11:0] slen_ff, slen_in;
   logic [15:0] prog_ff, prog_in;
   logic [4:0]  ver_ff, ver_in;
   logic [11:0] pinfo_ff, pinfo_in;
   pos_type     nes_ff, nes_in;
   logic [39:0] eb_ff, eb_in;

   logic [POSITION_WIDTH:0] nes_end;
   logic [POSITION_WIDTH:0] nxt;
   logic [POSITION_WIDTH:0] size;
   logic [2:0]              off;
   logic [39:0]             eb_shift;
   logic                    in_entry;
   logic                    emit_entry;
   result_type              entry_res;
   result_type              close_res;
   logic [1:0]              status;

   always_comb begin
      pos_in   = pos_ff;
      bad_in   = bad_ff;
      slen_in  = slen_ff;
      prog_in  = prog_ff;
      ver_in   = ver_ff;
      pinfo_in = pinfo_ff;
      nes_in   = nes_ff;
      eb_in    = eb_ff;

      // header capture and checks
      case (pos_ff)
         POS_TID: begin
            if (data_byte != cfg.expected_tid) bad_in = 1'b1;
         end
         POS_LEN_HI: begin
            if (!data_byte[7] || data_byte[6]) bad_in = 1'b1;
            slen_in = {data_byte[3:0], 8'h00};
         end
         POS_LEN_LO: begin
            slen_in = {slen_ff[11:8], data_byte};
            if ({1'b0, slen_in} + 13'd3 > cfg.max_section_bytes) bad_in = 1'b1;
         end
         POS_PROG_HI: prog_in = {data_byte, 8'h00};
         POS_PROG_LO: prog_in = {prog_ff[15:8], data_byte};
         POS_VERSION: ver_in = data_byte[5:1];
         POS_PINFO_HI: pinfo_in = {data_byte[3:0], 8'h00};
         POS_PINFO_LO: begin
            pinfo_in = {pinfo_ff[11:8], data_byte};
            if (pinfo_in[11:10] != 2'b00) bad_in = 1'b1;
            nes_in = pos_type'({1'b0, pinfo_in} + 13'd12);
         end
         default: ;
      endcase

      // stream entry window
      nes_end  = {1'b0, nes_ff} + (POSITION_WIDTH+1)'(ENTRY_LEN);
      in_entry = (pos_ff >= HEADER_BYTES) && !bad_ff && (pos_ff >= nes_ff)
                 && ({1'b0, pos_ff} < nes_end)
                 && ({1'b0, nes_ff} + 1'b1 < (POSITION_WIDTH+1)'(slen_ff));
      off        = 3'(pos_ff - nes_ff);
      eb_shift   = {eb_ff[31:0], data_byte};
      emit_entry = in_entry && (off == 3'(ENTRY_LEN - 1));
      nxt        = {1'b0, nes_ff} + (POSITION_WIDTH+1)'(ENTRY_LEN)
                   + (POSITION_WIDTH+1)'(eb_shift[11:0]);
      if (in_entry) begin
         if (emit_entry) begin
            eb_in  = '0;
            nes_in = nxt[POSITION_WIDTH] ? POS_MAX : nxt[POSITION_WIDTH-1:0];
         end else begin
            eb_in = eb_shift;
         end
      end

      if (pos_ff != POS_MAX) pos_in = pos_ff + 1'b1;

      // closing status
      size = {1'b0, pos_ff} + 1'b1;
      if (size < (POSITION_WIDTH+1)'(cfg.min_buffer_bytes)) status = STATUS_SHORT;
      else if (size < (POSITION_WIDTH+1)'(HEADER_BYTES)
               || (POSITION_WIDTH+1)'({1'b0, slen_ff} + 13'd3) > size)
         status = STATUS_TRUNCATED;
      else if (bad_in) status = STATUS_BAD_HDR;
      else status = STATUS_OK;

      entry_res.kind    = KIND_ENTRY;
      entry_res.es_type = eb_shift[39:32];
      entry_res.es_pid  = eb_shift[28:16];
      entry_res.prog_no = prog_in;
      entry_res.version = ver_in;
      entry_res.status  = STATUS_OK;
      entry_res.last    = 1'b0;

      close_res.kind    = KIND_CLOSE;
      close_res.es_type = '0;
      close_res.es_pid  = '0;
      close_res.prog_no = prog_in;
      close_res.version = ver_in;
      close_res.status  = status;
      close_res.last    = 1'b1;

      push.a = emit_entry ? entry_res : close_res;
      push.b = close_res;
      if (!accept) push.count = 2'd0;
      else push.count = {1'b0, emit_entry} + {1'b0, last_byte};

      // a closing result starts a fresh section
      if (last_byte) begin
         pos_in   = '0;
         bad_in   = 1'b0;
         slen_in  = '0;
         prog_in  = '0;
         ver_in   = '0;
         pinfo_in = '0;
         nes_in   = '0;
         eb_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         bad_ff   <= 1'b0;
         slen_ff  <= '0;
         prog_ff  <= '0;
         ver_ff   <= '0;
         pinfo_ff <= '0;
         nes_ff   <= '0;
         eb_ff    <= '0;
      end else if (accept) begin
         pos_ff   <= pos_in;
         bad_ff   <= bad_in;
         slen_ff  <= slen_in;
         prog_ff  <= prog_in;
         ver_ff   <= ver_in;
         pinfo_ff <= pinfo_in;
         nes_ff   <= nes_in;
         eb_ff    <= eb_in;
      end
   end

endmodule

// File: bench/tb_pmt_section_stream_parser_unit.sv
module tb_pmt_section_stream_parser_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import pmt_pkg::*;

   // index past the last register, writes there must be ignored
   localparam logic [1:0] CSR_SPARE_INDEX = 2'd3;

   localparam result_type NO_CHECK = '0;
   localparam result_type CLOSE_SHORT = '{kind: KIND_CLOSE, es_type: 8'h00,
      es_pid: 13'h0000, prog_no: 16'h0000, version: 5'h00,
      status: STATUS_SHORT, last: 1'b1};

   // one row of the directed table: the item, and a hand-written closing where typed is set
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       typed;
      result_type close;
   } stim_row_type;

   // one-byte buffer, a well-formed section with one extreme entry, another one-byte buffer
   localparam stim_row_type DIRECTED_ROWS [23] = '{
      '{8'h02, 1'b1, 1'b1, CLOSE_SHORT},
      '{8'h02, 1'b0, 1'b0, NO_CHECK},
      '{8'hB0, 1'b0, 1'b0, NO_CHECK},
      '{8'h12, 1'b0, 1'b0, NO_CHECK},
      '{8'h12, 1'b0, 1'b0, NO_CHECK},
      '{8'h34, 1'b0, 1'b0, NO_CHECK},
      '{8'hFF, 1'b0, 1'b0, NO_CHECK},
      '{8'h00, 1'b0, 1'b0, NO_CHECK},
      '{8'h00, 1'b0, 1'b0, NO_CHECK},
      '{8'hE1, 1'b0, 1'b0, NO_CHECK},
      '{8'h00, 1'b0, 1'b0, NO_CHECK},
      '{8'hF0, 1'b0, 1'b0, NO_CHECK},
      '{8'h00, 1'b0, 1'b0, NO_CHECK},
      '{8'hFF, 1'b0, 1'b0, NO_CHECK},
      '{8'hFF, 1'b0, 1'b0, NO_CHECK},
      '{8'hFF, 1'b0, 1'b0, NO_CHECK},
      '{8'hF0, 1'b0, 1'b0, NO_CHECK},
      '{8'h00, 1'b0, 1'b0, NO_CHECK},
      '{8'hDE, 1'b0, 1'b0, NO_CHECK},
      '{8'hAD, 1'b0, 1'b0, NO_CHECK},
      '{8'hBE, 1'b0, 1'b0, NO_CHECK},
      '{8'hEF, 1'b1, 1'b0, NO_CHECK},
      '{8'hFF, 1'b1, 1'b1, CLOSE_SHORT}
   };

   logic clock;
   logic reset;

   pmt_req_if req_bus ();
   pmt_rsp_if rsp_bus ();
   pmt_csr_if csr_bus ();

   pmt_section_stream_parser_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // 2 ns period
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // shadow copy of the configuration registers
   cfg_type cfg = '{expected_tid: 8'd2, max_section_bytes: 13'd1024,
                    min_buffer_bytes: 13'd16};

   // shadow copy of the parser state
   pos_type     sec_pos     = '0;
   logic        hdr_fault   = 1'b0;
   logic [11:0] sec_len     = '0;
   logic [15:0] prog_num    = '0;
   logic [4:0]  ver         = '0;
   logic [11:0] pinfo_len   = '0;
   pos_type     entry_at    = '0;
   logic [39:0] entry_shift = '0;

   // results still owed by the block, oldest first
   result_type awaited_results [$];
   int mismatch_count = 0;
   int items_sent = 0;

   // hand-written expectation travelling with the item on the request side
   logic       hand_typed;
   result_type hand_close;

   // when set, neither side idles
   bit quiet = 1'b0;

   // table id that the generated sections carry by default
   logic [7:0] gen_tid = 8'd2;

   function automatic pos_type clamp_pos(input int v);
      return (v > int'(POS_MAX)) ? POS_MAX : pos_type'(v);
   endfunction

   // advance the shadow parser by one byte, returns how many results it owes
   function automatic int parse_section_byte(input logic [7:0] b, input logic lst,
                                             output result_type first_res,
                                             output result_type second_res);
      result_type res [2];
      int p;
      int n;
      int size;
      logic [1:0] st;
      p = int'(sec_pos);
      n = 0;
      res[0] = '0;
      res[1] = '0;

      // header capture and checks
      case (sec_pos)
         POS_TID: begin
            if (b != cfg.expected_tid) hdr_fault = 1'b1;
         end
         POS_LEN_HI: begin
            // syntax bit must be set, zero bit clear
            if (!b[7] || b[6]) hdr_fault = 1'b1;
            sec_len = {b[3:0], 8'h00};
         end
         POS_LEN_LO: begin
            sec_len = sec_len | {4'h0, b};
            if (int'(sec_len) + 3 > int'(cfg.max_section_bytes)) hdr_fault = 1'b1;
         end
         POS_PROG_HI: prog_num = {b, 8'h00};
         POS_PROG_LO: prog_num = prog_num | {8'h00, b};
         POS_VERSION: ver = b[5:1];
         POS_PINFO_HI: pinfo_len = {b[3:0], 8'h00};
         POS_PINFO_LO: begin
            pinfo_len = pinfo_len | {4'h0, b};
            if (pinfo_len[11:10] != 2'b00) hdr_fault = 1'b1;
            entry_at = clamp_pos(int'(HEADER_BYTES) + int'(pinfo_len));
         end
         default: ;
      endcase

      // entry bytes, while the entry starts before the crc
      if (p >= int'(HEADER_BYTES) && !hdr_fault && p >= int'(entry_at) &&
          p < int'(entry_at) + ENTRY_LEN && int'(entry_at) + 1 < int'(sec_len)) begin
         entry_shift = {entry_shift[31:0], b};
         if (p - int'(entry_at) == ENTRY_LEN - 1) begin
            res[n] = '{kind: KIND_ENTRY, es_type: entry_shift[39:32],
                       es_pid: entry_shift[28:16], prog_no: prog_num,
                       version: ver, status: STATUS_OK, last: 1'b0};
            n++;
            entry_at = clamp_pos(int'(entry_at) + ENTRY_LEN + int'(entry_shift[11:0]));
            entry_shift = '0;
         end
      end

      if (sec_pos != POS_MAX) sec_pos = sec_pos + 1'b1;

      // closing result, size taken before saturation
      if (lst) begin
         size = p + 1;
         if (size < int'(cfg.min_buffer_bytes)) st = STATUS_SHORT;
         else if (size < int'(HEADER_BYTES) || int'(sec_len) + 3 > size)
            st = STATUS_TRUNCATED;
         else if (hdr_fault) st = STATUS_BAD_HDR;
         else st = STATUS_OK;
         res[n] = '{kind: KIND_CLOSE, es_type: 8'h00, es_pid: 13'h0000,
                    prog_no: prog_num, version: ver, status: st, last: 1'b1};
         n++;
         sec_pos = '0;
         hdr_fault = 1'b0;
         sec_len = '0;
         prog_num = '0;
         ver = '0;
         pinfo_len = '0;
         entry_at = '0;
         entry_shift = '0;
      end

      first_res = res[0];
      second_res = res[1];
      return n;
   endfunction

   // monitor: results checked first, then the accepted item predicted, then register writes
   always @(posedge clock) begin
      result_type got;
      result_type want;
      result_type r0;
      result_type r1;
      int n;
      if (!reset) begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got = '{kind: rsp_bus.kind, es_type: rsp_bus.es_type,
                    es_pid: rsp_bus.es_pid,
                    prog_no: rsp_bus.prog_no, version: rsp_bus.version,
                    status: rsp_bus.status, last: rsp_bus.last};
            if (awaited_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result: kind %0d type %h pid %h prog %h ver %0d st %0d",
                           got.kind, got.es_type, got.es_pid,
                           got.prog_no, got.version, got.status);
            end else begin
               want = awaited_results.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("mismatch at %0t", $realtime);
                     $display("  expected kind %0d type %h pid %h prog %h ver %0d st %0d last %0d",
                              want.kind, want.es_type, want.es_pid,
                              want.prog_no, want.version, want.status, want.last);
                     $display("  actual   kind %0d type %h pid %h prog %h ver %0d st %0d last %0d",
                              got.kind, got.es_type, got.es_pid,
                              got.prog_no, got.version, got.status, got.last);
                  end
               end
            end
         end

         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
            n = parse_section_byte(req_bus.data_byte, req_bus.last_byte, r0, r1);
            // typed rows replace the prediction with the closing written in the table
            if (hand_typed) awaited_results = {awaited_results, hand_close};
            else begin
               if (n > 0) awaited_results = {awaited_results, r0};
               if (n > 1) awaited_results = {awaited_results, r1};
            end
         end

         if (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1) begin
            case (csr_bus.index)
               CSR_TID:       cfg.expected_tid = csr_bus.data[7:0];
               CSR_MAX_BYTES: cfg.max_section_bytes = csr_bus.data;
               CSR_MIN_BYTES: cfg.min_buffer_bytes = csr_bus.data;
               default: ;
            endcase
         end
      end
   end

   // receiver: random stall before each result, none in quiet stretches
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 11);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
      end
   end

   // one item on the request channel; valid stays high when no gap is drawn
   task automatic send_item(input logic [7:0] b, input logic lst, input logic typed,
                            input result_type close);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data_byte <= b;
      req_bus.last_byte <= lst;
      hand_typed <= typed;
      hand_close <= close;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      items_sent++;
   endtask

   // stop sending and let every owed result come out
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [12:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
   endtask

   // new register setting, only once the block has gone quiet
   task automatic program_setting(input logic [12:0] tid_value, input logic [12:0] max_bytes,
                                  input logic [12:0] min_bytes);
      drain_results();
      write_reg(CSR_TID, tid_value);
      write_reg(CSR_MAX_BYTES, max_bytes);
      write_reg(CSR_MIN_BYTES, min_bytes);
      write_reg(CSR_SPARE_INDEX, 13'($urandom_range(0, 8191)));
      csr_bus.valid <= 1'b0;
      gen_tid = tid_value[7:0];
   endtask

   // mostly well-formed sections with random content, some noise and broken ones
   task automatic send_random_buffer();
      logic [7:0] buf_q [$];
      logic [7:0] tail_q [$];
      logic [11:0] decl12;
      logic [11:0] es_len;
      logic [7:0] b1;
      int pinfo;
      int n_ent;
      int decl_len;
      int cut;
      int extra;
      quiet = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
         // noise of 1 to 40 bytes, short buffers among it
         repeat ($urandom_range(1, 40)) buf_q = {buf_q, 8'($urandom_range(0, 255))};
      end else begin
         // program info length over the limit now and then
         pinfo = ($urandom_range(0, 15) == 0) ? $urandom_range(1024, 4095)
                                              : $urandom_range(0, 6);
         if (pinfo <= 6) repeat (pinfo) tail_q = {tail_q, 8'($urandom_range(0, 255))};
         n_ent = $urandom_range(0, 4);
         repeat (n_ent) begin
            tail_q = {tail_q, 8'($urandom_range(0, 255))};
            tail_q = {tail_q, 8'($urandom_range(0, 255))};
            tail_q = {tail_q, 8'($urandom_range(0, 255))};
            es_len = ($urandom_range(0, 11) == 0) ? 12'($urandom_range(0, 4095))
                                                  : 12'($urandom_range(0, 3));
            tail_q = {tail_q, {4'($urandom_range(0, 15)), es_len[11:8]}};
            tail_q = {tail_q, es_len[7:0]};
            if (es_len <= 3) repeat (es_len) tail_q = {tail_q, 8'($urandom_range(0, 255))};
         end
         // crc bytes
         repeat (4) tail_q = {tail_q, 8'($urandom_range(0, 255))};

         // declared length off by a few now and then: entries run into the crc
         decl_len = int'(HEADER_BYTES) - 3 + tail_q.size();
         if ($urandom_range(0, 5) == 0) decl_len = decl_len + $urandom_range(0, 8) - 4;
         if (decl_len < 0) decl_len = 0;
         decl12 = decl_len[11:0];

         buf_q = {buf_q, (($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                                      : gen_tid)};
         b1 = {1'b1, 1'b0, 2'($urandom_range(0, 3)), decl12[11:8]};
         if ($urandom_range(0, 15) == 0) b1[7] = 1'b0;
         if ($urandom_range(0, 15) == 0) b1[6] = 1'b1;
         buf_q = {buf_q, b1};
         buf_q = {buf_q, decl12[7:0]};
         repeat (7) buf_q = {buf_q, 8'($urandom_range(0, 255))};
         buf_q = {buf_q, {4'($urandom_range(0, 15)), 4'(pinfo >> 8)}};
         buf_q = {buf_q, 8'(pinfo)};
         foreach (tail_q[i]) buf_q = {buf_q, tail_q[i]};

         // buffer cut early, or with bytes past the section
         case ($urandom_range(0, 7))
            0: begin
               cut = $urandom_range(1, buf_q.size());
               while (buf_q.size() > cut) void'(buf_q.pop_back());
            end
            1: begin
               extra = $urandom_range(1, 6);
               repeat (extra) buf_q = {buf_q, 8'($urandom_range(0, 255))};
            end
            default: ;
         endcase
      end
      foreach (buf_q[i]) send_item(buf_q[i], i == buf_q.size() - 1, 1'b0, NO_CHECK);
   endtask

   task automatic random_phase(input int count);
      int target;
      target = items_sent + count;
      while (items_sent < target) begin
         send_random_buffer();
         // now and then hold off until everything owed has come out
         if ($urandom_range(0, 19) == 0) drain_results();
      end
   endtask

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.data_byte <= 8'h00;
      req_bus.last_byte <= 1'b0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= CSR_TID;
      csr_bus.data <= 13'h0000;
      hand_typed <= 1'b0;
      hand_close <= NO_CHECK;
      reset <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed rows under the reset setting
      foreach (DIRECTED_ROWS[i])
         send_item(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].typed,
                   DIRECTED_ROWS[i].close);
      random_phase(200);

      // widest allowed section, smallest header-sized buffer
      program_setting(13'h0002, 13'd4098, 13'd12);
      random_phase(150);

      // all limits at zero: every header fails the length check
      program_setting(13'h0000, 13'h0000, 13'h0000);
      random_phase(120);

      // all ones, the table id masked down to 8 bits
      program_setting(13'h1FFF, 13'h1FFF, 13'h1FFF);
      random_phase(80);

      // back to the reset values
      program_setting(13'h0002, 13'd1024, 13'd16);
      random_phase(150);

      drain_results();
      repeat (8) @(posedge clock);
      if (awaited_results.size() != 0) begin
         mismatch_count += awaited_results.size();
         $display("%0d expected results never arrived", awaited_results.size());
      end
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
